### hdl/mdu_pkg.sv
package mdu_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned HALF = XLEN / 2;
  // one quotient bit per back-end stage
  localparam int unsigned DIV_STEPS = XLEN;
  // queue between front and back, power of two
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_SDIV = 2'd0,
    OP_UDIV = 2'd1,
    OP_SMUL = 2'd2,
    OP_UMUL = 2'd3
  } op_code_t;

  // classified word handed from front to back
  typedef struct packed {
    logic            is_div;
    logic            spec;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] c;
  } entry_t;

  // word travelling down the back-end pipeline
  typedef struct packed {
    logic            is_div;
    logic            spec;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] r;
    logic [XLEN-1:0] q;
    logic [XLEN-1:0] d;
    logic [XLEN-1:0] x;
    logic [XLEN-1:0] c;
  } stage_t;

endpackage

### hdl/mdu_front.sv
module mdu_front (
  input  logic [1:0]                opcode,
  input  logic [mdu_pkg::XLEN-1:0]  operand_a,
  input  logic [mdu_pkg::XLEN-1:0]  operand_b,
  output mdu_pkg::entry_t           entry
);

  logic is_signed;
  logic an;
  logic bn;
  logic [mdu_pkg::XLEN-1:0] corr;

  always_comb begin
    is_signed = (opcode == mdu_pkg::OP_SDIV) || (opcode == mdu_pkg::OP_SMUL);
    an = is_signed & operand_a[mdu_pkg::XLEN-1];
    bn = is_signed & operand_b[mdu_pkg::XLEN-1];
    // signed high-half fix-up for the multiply
    corr = (an ? operand_b : '0) + (bn ? operand_a : '0);
    entry = '0;
    entry.is_div = (opcode == mdu_pkg::OP_SDIV) || (opcode == mdu_pkg::OP_UDIV);
    if (entry.is_div) begin
      if (operand_b == '0) begin
        // divide by zero: quotient all ones (one for a negative signed dividend), remainder is the dividend
        entry.spec = 1'b1;
        entry.a = an ? mdu_pkg::XLEN'(1) : '1;
        entry.c = operand_a;
      end else begin
        entry.a = an ? (~operand_a + 1'b1) : operand_a;
        entry.b = bn ? (~operand_b + 1'b1) : operand_b;
        entry.neg_q = an ^ bn;
        entry.neg_r = an;
      end
    end else begin
      entry.a = operand_a;
      entry.b = operand_b;
      entry.c = corr;
    end
  end

endmodule

### hdl/mdu_fifo.sv
module mdu_fifo #(
  parameter int unsigned DEPTH = mdu_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mdu_pkg::entry_t  wr_data,
  output logic             full,
  input  logic             pop,
  output mdu_pkg::entry_t  rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mdu_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

endmodule

### hdl/mdu_back.sv
module mdu_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  mdu_pkg::entry_t           q_data,
  output logic                      q_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [mdu_pkg::XLEN-1:0]  lo_word,
  output logic [mdu_pkg::XLEN-1:0]  hi_word
);

  localparam int unsigned N = mdu_pkg::DIV_STEPS;
  localparam int unsigned XL = mdu_pkg::XLEN;
  localparam int unsigned HF = mdu_pkg::HALF;

  function automatic mdu_pkg::stage_t step_fn(input mdu_pkg::stage_t s, input int unsigned k);
    mdu_pkg::stage_t n;
    logic [XL:0]   rem2;
    logic [XL:0]   diff;
    logic [XL-1:0] mid;
    n = s;
    rem2 = '0;
    diff = '0;
    mid = '0;
    if (s.is_div) begin
      if (!s.spec) begin
        // restoring step: one quotient bit
        rem2 = {s.r, s.q[XL-1]};
        diff = rem2 - {1'b0, s.d};
        n.q = {s.q[XL-2:0], ~diff[XL]};
        n.r = diff[XL] ? rem2[XL-1:0] : diff[XL-1:0];
      end
    end else if (k == 0) begin
      // partial products
      n.q = s.q[HF-1:0] * s.d[HF-1:0];
      n.d = s.q[HF-1:0] * s.d[XL-1:HF];
      n.x = s.q[XL-1:HF] * s.d[HF-1:0];
      n.r = s.q[XL-1:HF] * s.d[XL-1:HF];
    end else if (k == 1) begin
      mid = {{HF{1'b0}}, s.q[XL-1:HF]} + {{HF{1'b0}}, s.d[HF-1:0]}
          + {{HF{1'b0}}, s.x[HF-1:0]};
      n.q = {mid[HF-1:0], s.q[HF-1:0]};
      n.r = s.r + {{HF{1'b0}}, s.d[XL-1:HF]} + {{HF{1'b0}}, s.x[XL-1:HF]}
          + {{HF{1'b0}}, mid[XL-1:HF]};
    end else if (k == 2) begin
      n.r = s.r - s.c;
    end
    return n;
  endfunction

  mdu_pkg::stage_t st [N+1];
  logic [N:0] v;
  logic       out_v;
  logic       en;

  assign en        = !out_v || out_pop;
  assign q_pop     = en && !q_empty;
  assign out_empty = !out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v     <= {v[N-1:0], !q_empty};
      out_v <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].is_div <= q_data.is_div;
      st[0].spec   <= q_data.spec;
      st[0].neg_q  <= q_data.neg_q;
      st[0].neg_r  <= q_data.neg_r;
      st[0].r      <= q_data.spec ? q_data.c : '0;
      st[0].q      <= q_data.a;
      st[0].d      <= q_data.b;
      st[0].x      <= '0;
      st[0].c      <= q_data.c;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) st[k+1] <= step_fn(st[k], k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_word <= (st[N].is_div && st[N].neg_q) ? (~st[N].q + 1'b1) : st[N].q;
      hi_word <= (st[N].is_div && st[N].neg_r) ? (~st[N].r + 1'b1) : st[N].r;
    end
  end

endmodule

### hdl/int64_mult_div_unit.sv
// a word pushed into the queue passes, on its way to the result ports,
// one issue stage out of the queue, 64 division steps and one output register
// throughput: one word per cycle, for multiply and divide alike, but
// the back pipeline holds as a whole while its output word waits for pop
// reset: synchronous rst empties the queue and clears all valid bits
module int64_mult_div_unit #(
  parameter int unsigned FIFO_DEPTH = mdu_pkg::FIFO_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                opcode,
  input  logic [mdu_pkg::XLEN-1:0]  operand_a,
  input  logic [mdu_pkg::XLEN-1:0]  operand_b,
  output logic                      empty,
  input  logic                      pop,
  output logic [mdu_pkg::XLEN-1:0]  lo_word,
  output logic [mdu_pkg::XLEN-1:0]  hi_word
);

  // classified word, queue output and queue handshake
  mdu_pkg::entry_t front_entry;
  mdu_pkg::entry_t q_data;
  logic            q_empty;
  logic            q_pop;

  // front: operand magnitudes, sign fix-ups, divide-by-zero results
  mdu_front u_front (
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .entry     (front_entry)
  );

  // short queue lets the front keep taking words while the back holds
  mdu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_entry),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // back: multiply in three stages, divide one bit per stage, equal length
  mdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .lo_word   (lo_word),
    .hi_word   (hi_word)
  );

endmodule
